/* hw/rtl/ttk_pkg.sv */
// Shared types, codes and controller/datapath command set for the top-k winner tree.
`timescale 1ns / 1ps
package ttk_pkg;

  typedef struct packed {
    logic [1:0] cmd;
    logic       left_wins;
  } req_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [5:0] left_member;
    logic [5:0] right_member;
    logic [5:0] taken_member;
  } rsp_t;

  localparam logic [1:0] CMD_EXTRACT = 2'd0;
  localparam logic [1:0] CMD_ANSWER  = 2'd1;
  localparam logic [1:0] CMD_ABANDON = 2'd2;

  localparam logic [2:0] KIND_COMPARE   = 3'd0;
  localparam logic [2:0] KIND_OK        = 3'd1;
  localparam logic [2:0] KIND_EXHAUSTED = 3'd2;
  localparam logic [2:0] KIND_ABORTED   = 3'd3;
  localparam logic [2:0] KIND_ORDER     = 3'd4;

  localparam int unsigned OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE    = 5'd0;
  localparam logic [OP_W-1:0] OP_CFG     = 5'd1;
  localparam logic [OP_W-1:0] OP_LEAF    = 5'd2;
  localparam logic [OP_W-1:0] OP_RINIT   = 5'd3;
  localparam logic [OP_W-1:0] OP_PAIR1   = 5'd4;
  localparam logic [OP_W-1:0] OP_PAIR2   = 5'd5;
  localparam logic [OP_W-1:0] OP_BYE     = 5'd6;
  localparam logic [OP_W-1:0] OP_RNEXT   = 5'd7;
  localparam logic [OP_W-1:0] OP_ROOT    = 5'd8;
  localparam logic [OP_W-1:0] OP_ORDER   = 5'd9;
  localparam logic [OP_W-1:0] OP_EXH     = 5'd10;
  localparam logic [OP_W-1:0] OP_ABORT   = 5'd11;
  localparam logic [OP_W-1:0] OP_SEED0   = 5'd12;
  localparam logic [OP_W-1:0] OP_TAKE    = 5'd13;
  localparam logic [OP_W-1:0] OP_ANSWER  = 5'd14;
  localparam logic [OP_W-1:0] OP_SEEDED  = 5'd15;
  localparam logic [OP_W-1:0] OP_RD_ROOT = 5'd16;
  localparam logic [OP_W-1:0] OP_RD_PAR  = 5'd17;
  localparam logic [OP_W-1:0] OP_RD_CH   = 5'd18;
  localparam logic [OP_W-1:0] OP_RD_WL   = 5'd19;
  localparam logic [OP_W-1:0] OP_RD_WR   = 5'd20;
  localparam logic [OP_W-1:0] OP_BYPASS  = 5'd21;
  localparam logic [OP_W-1:0] OP_REQ     = 5'd22;
  localparam logic [OP_W-1:0] OP_FIN     = 5'd23;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } ctl_t;

  typedef struct packed {
    logic awaiting;
    logic root_none;
    logic seeded;
    logic m_zero;
    logic leaf_last;
    logic round_end;
    logic pair_ok;
    logic len_one;
    logic cur_lt_total;
    logic cur_is_root;
    logic lw_empty;
    logic rw_empty;
  } sts_t;

endpackage

/* hw/rtl/ttk_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ttk_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);
  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* hw/rtl/ttk_dpath.sv */
// Datapath: tree memories, walk and build registers, result register.
`timescale 1ns / 1ps
module ttk_dpath
  import ttk_pkg::*;
#(
  parameter int unsigned MAX_MEMBERS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctl_t       ctl_i,
  input  req_t       req_i,
  input  logic [6:0] cfg_wdata_i,
  output sts_t       sts_o,
  output rsp_t       rsp_o,
  output logic       rsp_valid_o
);
  localparam int unsigned NODE_MAX = 2 * MAX_MEMBERS - 1;
  localparam int unsigned NW = $clog2(NODE_MAX);
  localparam int unsigned WW = $clog2(MAX_MEMBERS + 1);
  localparam logic [WW-1:0] EMPTY = WW'(MAX_MEMBERS);

  logic [NW-1:0] m_q, total_q, root_q, cur_q, lnode_q, rnode_q, bi_q;
  logic [NW-1:0] s_q, c_q, b_q, ns_q, nc_q, nb_q;
  logic          bv_q, nbv_q, root_none_q, seeded_q, await_q;
  logic [WW-1:0] last_q, lw_q, rw_q;
  logic [OP_W-1:0] op_q;
  rsp_t          rsp_q, rsp_d;
  logic          rsp_valid_q, rsp_valid_d;

  logic [NW:0]   len, j0, j1;
  logic [NW-1:0] e0, e1;

  logic            win_we, par_we, ch_we;
  logic [NW-1:0]   win_wa, win_ra, par_wa, par_wd, ch_wa;
  logic [WW-1:0]   win_wd, win_rd;
  logic [NW-1:0]   par_rd;
  logic [2*NW-1:0] ch_wd, ch_rd;
  logic [WW-1:0]   pick;

  function automatic logic [5:0] to6(input logic [WW-1:0] v);
    logic [WW+5:0] ext;
    ext = {6'b0, v};
    return ext[5:0];
  endfunction

  // Round element j: the consecutive run first, then the carried bye node.
  assign len = {1'b0, c_q} + {{NW{1'b0}}, bv_q};
  assign j0  = {1'b0, bi_q};
  assign j1  = {1'b0, bi_q} + 1'b1;
  assign e0  = (j0 < {1'b0, c_q}) ? (s_q + bi_q) : b_q;
  assign e1  = (j1 < {1'b0, c_q}) ? NW'(s_q + j1[NW-1:0]) : b_q;
  assign pick = (lw_q == EMPTY) ? rw_q : lw_q;

  always_comb begin
    win_we = 1'b0;
    win_wa = cur_q;
    win_wd = EMPTY;
    win_ra = lnode_q;
    par_we = 1'b0;
    par_wa = e0;
    par_wd = total_q;
    ch_we  = 1'b0;
    ch_wa  = total_q;
    ch_wd  = {e0, e1};
    case (ctl_i.op)
      OP_LEAF: begin
        win_we = 1'b1;
        win_wa = bi_q;
        win_wd = WW'(bi_q);
      end
      OP_PAIR1: begin
        win_we = 1'b1;
        win_wa = total_q;
        par_we = 1'b1;
        ch_we  = 1'b1;
      end
      OP_PAIR2: begin
        par_we = 1'b1;
        par_wa = e1;
      end
      OP_TAKE: begin
        win_we = 1'b1;
        win_wa = NW'(last_q);
      end
      OP_ANSWER: begin
        win_we = 1'b1;
        win_wd = req_i.left_wins ? lw_q : rw_q;
      end
      OP_BYPASS: begin
        win_we = 1'b1;
        win_wd = pick;
      end
      OP_RD_WR:                win_ra = rnode_q;
      OP_RD_ROOT, OP_SEEDED:   win_ra = root_q;
      default: ;
    endcase
  end

  // Result for the current step; the root winner is read straight off the RAM.
  always_comb begin
    rsp_d = '0;
    rsp_valid_d = 1'b0;
    case (ctl_i.op)
      OP_ORDER: begin
        rsp_valid_d = 1'b1;
        rsp_d.result_kind = KIND_ORDER;
      end
      OP_EXH: begin
        rsp_valid_d = 1'b1;
        rsp_d.result_kind = KIND_EXHAUSTED;
      end
      OP_ABORT: begin
        rsp_valid_d = 1'b1;
        rsp_d.result_kind = KIND_ABORTED;
      end
      OP_REQ: begin
        rsp_valid_d = 1'b1;
        rsp_d.result_kind = KIND_COMPARE;
        rsp_d.left_member = to6(lw_q);
        rsp_d.right_member = to6(rw_q);
      end
      OP_FIN: begin
        rsp_valid_d = 1'b1;
        if (win_rd == EMPTY) begin
          rsp_d.result_kind = KIND_EXHAUSTED;
        end else begin
          rsp_d.result_kind = KIND_OK;
          rsp_d.taken_member = to6(win_rd);
        end
      end
      default: ;
    endcase
  end

  ttk_ram #(.W(WW), .D(NODE_MAX)) u_win (
    .clk_i, .we_i(win_we), .waddr_i(win_wa), .wdata_i(win_wd),
    .raddr_i(win_ra), .rdata_o(win_rd)
  );
  ttk_ram #(.W(NW), .D(NODE_MAX)) u_par (
    .clk_i, .we_i(par_we), .waddr_i(par_wa), .wdata_i(par_wd),
    .raddr_i(cur_q), .rdata_o(par_rd)
  );
  ttk_ram #(.W(2 * NW), .D(NODE_MAX)) u_child (
    .clk_i, .we_i(ch_we), .waddr_i(ch_wa), .wdata_i(ch_wd),
    .raddr_i(cur_q), .rdata_o(ch_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= '0; total_q <= '0; root_q <= '0; cur_q <= '0;
      lnode_q <= '0; rnode_q <= '0; bi_q <= '0;
      s_q <= '0; c_q <= '0; b_q <= '0; ns_q <= '0; nc_q <= '0; nb_q <= '0;
      bv_q <= 1'b0; nbv_q <= 1'b0;
      root_none_q <= 1'b1; seeded_q <= 1'b0; await_q <= 1'b0;
      last_q <= '0; lw_q <= '0; rw_q <= '0;
      op_q <= OP_NONE;
      rsp_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      op_q <= ctl_i.op;
      rsp_valid_q <= rsp_valid_d;
      rsp_q <= rsp_d;
      // capture read data in the cycle after the read was issued
      case (op_q)
        OP_RD_PAR: cur_q <= par_rd;
        OP_RD_CH: begin
          lnode_q <= ch_rd[2*NW-1:NW];
          rnode_q <= ch_rd[NW-1:0];
        end
        OP_RD_WL, OP_RD_ROOT, OP_SEEDED: lw_q <= win_rd;
        OP_RD_WR: rw_q <= win_rd;
        default: ;
      endcase
      case (ctl_i.op)
        OP_CFG: begin
          if ({25'b0, cfg_wdata_i} > 32'(MAX_MEMBERS)) begin
            m_q <= NW'(MAX_MEMBERS);
            total_q <= NW'(MAX_MEMBERS);
          end else begin
            m_q <= NW'(cfg_wdata_i);
            total_q <= NW'(cfg_wdata_i);
          end
          root_none_q <= (cfg_wdata_i == 7'd0);
          seeded_q <= 1'b0;
          last_q <= '0;
          cur_q <= '0;
          await_q <= 1'b0;
          bi_q <= '0;
        end
        OP_LEAF: bi_q <= bi_q + 1'b1;
        OP_RINIT: begin
          s_q <= '0; c_q <= m_q; bv_q <= 1'b0; bi_q <= '0;
          ns_q <= total_q; nc_q <= '0; nbv_q <= 1'b0;
        end
        OP_PAIR2: begin
          total_q <= total_q + 1'b1;
          nc_q <= nc_q + 1'b1;
          bi_q <= bi_q + NW'(2);
        end
        OP_BYE: begin
          nb_q <= e0;
          nbv_q <= 1'b1;
          bi_q <= bi_q + 1'b1;
        end
        OP_RNEXT: begin
          s_q <= ns_q; c_q <= nc_q; b_q <= nb_q; bv_q <= nbv_q; bi_q <= '0;
          ns_q <= total_q; nc_q <= '0; nbv_q <= 1'b0;
        end
        OP_ROOT: root_q <= (c_q == NW'(1)) ? s_q : b_q;
        OP_ABORT: await_q <= 1'b0;
        OP_SEED0: cur_q <= m_q;
        OP_TAKE:  cur_q <= NW'(last_q);
        OP_ANSWER: begin
          await_q <= 1'b0;
          if (!seeded_q) begin
            cur_q <= cur_q + 1'b1;
          end
        end
        OP_SEEDED: seeded_q <= 1'b1;
        OP_REQ: await_q <= 1'b1;
        OP_FIN: begin
          if (win_rd != EMPTY) begin
            last_q <= win_rd;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts_o.awaiting     = await_q;
    sts_o.root_none    = root_none_q;
    sts_o.seeded       = seeded_q;
    sts_o.m_zero       = (m_q == '0);
    sts_o.leaf_last    = (bi_q == NW'(m_q - 1'b1));
    sts_o.round_end    = (j0 >= len);
    sts_o.pair_ok      = (j1 < len);
    sts_o.len_one      = (len == (NW+1)'(1));
    sts_o.cur_lt_total = (cur_q < total_q);
    sts_o.cur_is_root  = (cur_q == root_q);
    sts_o.lw_empty     = (lw_q == EMPTY);
    sts_o.rw_empty     = (rw_q == EMPTY);
  end

  assign rsp_o = rsp_q;
  assign rsp_valid_o = rsp_valid_q;
endmodule

/* hw/rtl/ttk_ctrl.sv */
// Controller: sequences build, seeding and refill walks over the datapath.
`timescale 1ns / 1ps
module ttk_ctrl
  import ttk_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  input  logic cfg_we_i,
  input  sts_t sts_i,
  output ctl_t ctl_o,
  output logic busy_o
);
  localparam int unsigned SW = 4;
  localparam logic [SW-1:0] S_IDLE  = 4'd0;
  localparam logic [SW-1:0] S_LEAF  = 4'd1;
  localparam logic [SW-1:0] S_RINIT = 4'd2;
  localparam logic [SW-1:0] S_CHK   = 4'd3;
  localparam logic [SW-1:0] S_PAIR  = 4'd4;
  localparam logic [SW-1:0] S_PAIR2 = 4'd5;
  localparam logic [SW-1:0] S_SEED  = 4'd6;
  localparam logic [SW-1:0] S_CLIMB = 4'd7;
  localparam logic [SW-1:0] S_PARW  = 4'd8;
  localparam logic [SW-1:0] S_RCH   = 4'd9;
  localparam logic [SW-1:0] S_WCH   = 4'd10;
  localparam logic [SW-1:0] S_WL    = 4'd11;
  localparam logic [SW-1:0] S_WR    = 4'd12;
  localparam logic [SW-1:0] S_WW    = 4'd13;
  localparam logic [SW-1:0] S_DEC   = 4'd14;
  localparam logic [SW-1:0] S_FIN   = 4'd15;

  logic [SW-1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o.op = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (cfg_we_i) begin
          ctl_o.op = OP_CFG;
          state_d = S_LEAF;
        end else if (start_i) begin
          if (req_i.cmd == CMD_EXTRACT) begin
            if (sts_i.awaiting) begin
              ctl_o.op = OP_ORDER;
            end else if (sts_i.root_none) begin
              ctl_o.op = OP_EXH;
            end else if (!sts_i.seeded) begin
              ctl_o.op = OP_SEED0;
              state_d = S_SEED;
            end else begin
              ctl_o.op = OP_TAKE;
              state_d = S_CLIMB;
            end
          end else if (req_i.cmd == CMD_ABANDON && sts_i.awaiting) begin
            ctl_o.op = OP_ABORT;
          end else if (req_i.cmd == CMD_ANSWER && sts_i.awaiting) begin
            ctl_o.op = OP_ANSWER;
            state_d = sts_i.seeded ? S_CLIMB : S_SEED;
          end else begin
            ctl_o.op = OP_ORDER;
          end
        end
      end
      S_LEAF: begin
        if (sts_i.m_zero) begin
          state_d = S_IDLE;
        end else begin
          ctl_o.op = OP_LEAF;
          if (sts_i.leaf_last) state_d = S_RINIT;
        end
      end
      S_RINIT: begin
        ctl_o.op = OP_RINIT;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (sts_i.len_one) begin
          ctl_o.op = OP_ROOT;
          state_d = S_IDLE;
        end else begin
          state_d = S_PAIR;
        end
      end
      S_PAIR: begin
        if (sts_i.round_end) begin
          ctl_o.op = OP_RNEXT;
          state_d = S_CHK;
        end else if (sts_i.pair_ok) begin
          ctl_o.op = OP_PAIR1;
          state_d = S_PAIR2;
        end else begin
          ctl_o.op = OP_BYE;
        end
      end
      S_PAIR2: begin
        ctl_o.op = OP_PAIR2;
        state_d = S_PAIR;
      end
      S_SEED: begin
        if (sts_i.cur_lt_total) begin
          ctl_o.op = OP_RD_CH;
          state_d = S_WCH;
        end else begin
          ctl_o.op = OP_SEEDED;
          state_d = S_FIN;
        end
      end
      S_CLIMB: begin
        if (sts_i.cur_is_root) begin
          ctl_o.op = OP_RD_ROOT;
          state_d = S_FIN;
        end else begin
          ctl_o.op = OP_RD_PAR;
          state_d = S_PARW;
        end
      end
      S_PARW: state_d = S_RCH;
      S_RCH: begin
        ctl_o.op = OP_RD_CH;
        state_d = S_WCH;
      end
      S_WCH: state_d = S_WL;
      S_WL: begin
        ctl_o.op = OP_RD_WL;
        state_d = S_WR;
      end
      S_WR: begin
        ctl_o.op = OP_RD_WR;
        state_d = S_WW;
      end
      S_WW: state_d = S_DEC;
      S_DEC: begin
        if (sts_i.seeded && (sts_i.lw_empty || sts_i.rw_empty)) begin
          ctl_o.op = OP_BYPASS;
          state_d = S_CLIMB;
        end else begin
          ctl_o.op = OP_REQ;
          state_d = S_IDLE;
        end
      end
      S_FIN: begin
        // root winner read data is valid on the RAM output this cycle
        ctl_o.op = OP_FIN;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
endmodule

/* hw/rtl/tournament_tree_top_k.sv */
// Top level of the top-k winner-tree selector with external comparisons.
// Immediate answers (out of order, exhausted, aborted) are given from the idle state
// without a walk; seeding ends in a compare request or the closing ok, and a refill
// climbs level by level (compare or bypass) and reads the root winner at the root.
// Throughput: one request at a time; busy_o is high while a walk or a rebuild runs.
// A member count write rebuilds the tree: leaves first, then the pairing rounds.
// Reset gives an empty tree (member count 0); results cannot be stalled by the receiver.
`timescale 1ns / 1ps
module tournament_tree_top_k
  import ttk_pkg::*;
#(
  parameter int unsigned MAX_MEMBERS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request channel: accepted when start_i is high and busy_o is low
  input  logic       start_i,
  output logic       busy_o,
  input  req_t       req_i,
  // result strobe: one cycle, no back-pressure
  output logic       rsp_valid_o,
  output rsp_t       rsp_o,
  // member count register
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i
);
  ctl_t ctl;
  sts_t sts;

  // Controller decides each step; the datapath owns the node memories
  // (winner, parent, children) and all walk/build registers.
  ttk_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .req_i, .cfg_we_i,
    .sts_i(sts), .ctl_o(ctl), .busy_o
  );

  ttk_dpath #(.MAX_MEMBERS(MAX_MEMBERS)) u_dpath (
    .clk_i, .rst_ni, .ctl_i(ctl), .req_i, .cfg_wdata_i,
    .sts_o(sts), .rsp_o, .rsp_valid_o
  );
endmodule

/* dv/tournament_tree_top_k_tb.sv */
// Self-checking testbench for the top-k winner-tree selector, with its own tree predictor.
`timescale 1ns / 1ps
module tournament_tree_top_k_tb;
  import ttk_pkg::*;

  localparam int MAXM     = 64;
  localparam int NODES    = 2 * MAXM - 1;
  localparam int NO_NODE  = NODES;  // link code for "no node"
  localparam int EMPTY_W  = MAXM;   // winner code for "empty"
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 600000;

  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  req_t       req_i;
  logic       rsp_valid_o;
  rsp_t       rsp_o;
  logic       cfg_we_i;
  logic [6:0] cfg_wdata_i;

  tournament_tree_top_k uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predicted tree state. Kept in step with the block: updated when a request
  // is accepted or the member count is written.
  // ---------------------------------------------------------------------------
  int  p_count;
  int  p_win   [NODES];
  int  p_left  [NODES];
  int  p_right [NODES];
  int  p_par   [NODES];
  int  p_total;
  int  p_root;
  bit  p_seeded;
  int  p_last;
  int  p_cursor;
  bit  p_waiting;

  rsp_t pending_rsp[$];  // results still owed by the block, oldest first
  int   n_fail;
  int   n_items;
  int   n_rsp;
  int   n_cfg;
  int   n_taken;
  int   n_aborts;
  bit   no_idle;         // suppresses sender gaps during the long burst
  longint cycles;

  function automatic int winner_at(int node);
    return node < NODES ? p_win[node] : EMPTY_W;
  endfunction

  function automatic rsp_t mk_rsp(logic [2:0] kind, int l, int r, int t);
    rsp_t x;
    x.result_kind  = kind;
    x.left_member  = l[5:0];
    x.right_member = r[5:0];
    x.taken_member = t[5:0];
    return x;
  endfunction

  // Pair adjacent entries round by round; an odd last entry gets a bye.
  function automatic void rebuild_tree(int m);
    int rnd[MAXM];
    int len, nxt, n;
    for (int i = 0; i < NODES; i++) begin
      p_win[i] = EMPTY_W; p_left[i] = NO_NODE; p_right[i] = NO_NODE; p_par[i] = NO_NODE;
    end
    p_count = m;
    p_total = m; p_root = NO_NODE; p_seeded = 0; p_last = 0; p_cursor = 0; p_waiting = 0;
    if (m == 0) return;
    for (int i = 0; i < m; i++) begin
      p_win[i] = i; rnd[i] = i;
    end
    len = m;
    while (len > 1) begin
      nxt = 0;
      for (int i = 0; i < len; i += 2) begin
        if (i + 1 < len && p_total < NODES) begin
          n = p_total++;
          p_left[n] = rnd[i]; p_right[n] = rnd[i+1];
          p_par[rnd[i]] = n; p_par[rnd[i+1]] = n;
          rnd[nxt++] = n;
        end else begin
          rnd[nxt++] = rnd[i];
        end
      end
      len = nxt;
    end
    p_root = rnd[0];
  endfunction

  function automatic rsp_t compare_at(int node);
    p_cursor = node;
    p_waiting = 1;
    return mk_rsp(KIND_COMPARE, winner_at(p_left[node]), winner_at(p_right[node]), 0);
  endfunction

  function automatic rsp_t root_result();
    int t;
    t = p_root < NODES ? p_win[p_root] : EMPTY_W;
    if (t >= EMPTY_W) return mk_rsp(KIND_EXHAUSTED, 0, 0, 0);
    p_last = t;
    return mk_rsp(KIND_OK, 0, 0, t);
  endfunction

  // First extraction: play internal nodes in number order from 'from'.
  function automatic rsp_t seed_from(int from);
    for (int n = from; n < p_total && n < NODES; n++)
      if (p_left[n] != NO_NODE) return compare_at(n);
    p_seeded = 1;
    return root_result();
  endfunction

  // Refill: climb toward the root, passing survivors past empty siblings.
  function automatic rsp_t climb_from(int c);
    int p, l, r;
    while (c < NODES && p_par[c] != NO_NODE) begin
      p = p_par[c];
      l = winner_at(p_left[p]);
      r = winner_at(p_right[p]);
      if (l >= EMPTY_W || r >= EMPTY_W) begin
        p_win[p] = (l >= EMPTY_W) ? r : l;
        c = p;
      end else begin
        return compare_at(p);
      end
    end
    return root_result();
  endfunction

  function automatic rsp_t predict_request(req_t q);
    int n;
    if (q.cmd == CMD_EXTRACT) begin
      if (p_waiting) return mk_rsp(KIND_ORDER, 0, 0, 0);
      if (p_root >= NODES) return mk_rsp(KIND_EXHAUSTED, 0, 0, 0);
      if (!p_seeded) return seed_from(0);
      p_win[p_last] = EMPTY_W;
      return climb_from(p_last);
    end
    if ((q.cmd == CMD_ANSWER || q.cmd == CMD_ABANDON) && p_waiting) begin
      n = p_cursor;
      p_waiting = 0;
      if (q.cmd == CMD_ABANDON) return mk_rsp(KIND_ABORTED, 0, 0, 0);
      p_win[n] = q.left_wins ? winner_at(p_left[n]) : winner_at(p_right[n]);
      return p_seeded ? climb_from(n) : seed_from(n + 1);
    end
    return mk_rsp(KIND_ORDER, 0, 0, 0);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: the strobe lasts one cycle, so every edge is looked at.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp_valid_o) begin
      n_rsp++;
      if (pending_rsp.size() == 0) begin
        $error("unexpected result kind=%0d", rsp_o.result_kind);
        n_fail++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp_o.result_kind !== e.result_kind) begin
          $error("result_kind exp %0d got %0d", e.result_kind, rsp_o.result_kind);
          n_fail++;
        end
        if (rsp_o.left_member !== e.left_member) begin
          $error("left_member exp %0d got %0d", e.left_member, rsp_o.left_member);
          n_fail++;
        end
        if (rsp_o.right_member !== e.right_member) begin
          $error("right_member exp %0d got %0d", e.right_member, rsp_o.right_member);
          n_fail++;
        end
        if (rsp_o.taken_member !== e.taken_member) begin
          $error("taken_member exp %0d got %0d", e.taken_member, rsp_o.taken_member);
          n_fail++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one request. start_i stays high after acceptance so back-to-back
  // requests follow without a gap; park_sender lowers it between phases.
  task automatic send_request(logic [1:0] cmd, logic lw);
    req_t q;
    int gap;
    if (!no_idle && $urandom_range(99) < 28) begin
      gap = $urandom_range(4, 1);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    q.cmd = cmd;
    q.left_wins = lw;
    start_i <= 1'b1;
    req_i   <= q;
    do @(posedge clk_i); while (busy_o);
    pending_rsp = {pending_rsp, predict_request(q)};
    n_items++;
    if (pending_rsp[$].result_kind == KIND_OK) n_taken++;
    if (pending_rsp[$].result_kind == KIND_ABORTED) n_aborts++;
  endtask

  // Stop sending and wait for every owed result, plus a short settle.
  task automatic park_sender();
    start_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // Member count write; only called with the sender parked.
  task automatic write_count(int unsigned v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[6:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rebuild_tree(v[6:0] > MAXM ? MAXM : int'(v[6:0]));
    n_cfg++;
  endtask

  // Extract with a random answer to every compare until the tree runs dry.
  task automatic drain_tree();
    send_request(CMD_EXTRACT, 1'b0);
    while (pending_rsp[$].result_kind != KIND_EXHAUSTED) begin
      if (p_waiting) send_request(CMD_ANSWER, 1'($urandom_range(1)));
      else send_request(CMD_EXTRACT, 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty tree out of reset: extract is exhausted, everything else out of order.
  task automatic test_empty_tree();
    send_request(CMD_EXTRACT, 1'b0);
    send_request(CMD_ANSWER, 1'b1);
    send_request(CMD_ABANDON, 1'b0);
    send_request(CMD_SPARE, 1'b1);
    park_sender();
  endtask

  // Single member comes out with no compare, then exhausted twice.
  task automatic test_single_member();
    write_count(1);
    send_request(CMD_EXTRACT, 1'b0);
    send_request(CMD_EXTRACT, 1'b0);
    send_request(CMD_EXTRACT, 1'b0);
    park_sender();
  endtask

  // Abandon mid-walk, out-of-order commands while a compare is open,
  // then a rebuild with a compare still outstanding.
  task automatic test_protocol_errors();
    write_count(5);
    send_request(CMD_EXTRACT, 1'b0);
    send_request(CMD_EXTRACT, 1'b0);  // extract while waiting
    send_request(CMD_SPARE, 1'b0);
    send_request(CMD_ABANDON, 1'b0);
    send_request(CMD_ABANDON, 1'b0);  // nothing pending now
    send_request(CMD_EXTRACT, 1'b0);  // restarts seeding
    send_request(CMD_ANSWER, 1'b1);
    send_request(CMD_ANSWER, 1'b0);
    park_sender();
    write_count(3);                   // drops the open compare
    drain_tree();
    park_sender();
  endtask

  // Largest tree, and a count above the maximum that saturates.
  task automatic test_full_size();
    write_count(MAXM);
    drain_tree();
    park_sender();
    write_count(127);
    send_request(CMD_EXTRACT, 1'b0);
    send_request(CMD_ANSWER, 1'b1);
    park_sender();
  endtask

  // Random sets: mostly well-formed walks, some noise and abandons.
  task automatic test_random_walks(int budget);
    int m, r, per_set;
    while (budget > 0) begin
      r = $urandom_range(99);
      if (r < 5) m = MAXM;
      else if (r < 8) m = $urandom_range(127, 65);
      else if (r < 11) m = 0;
      else m = $urandom_range(12, 1);
      write_count(m);
      per_set = 0;
      while (budget > 0 && per_set < 120) begin
        r = $urandom_range(99);
        if (r < 7) send_request(2'($urandom_range(3)), 1'($urandom_range(1)));
        else if (p_waiting && r < 11) send_request(CMD_ABANDON, 1'($urandom_range(1)));
        else if (p_waiting) send_request(CMD_ANSWER, 1'($urandom_range(1)));
        else send_request(CMD_EXTRACT, 1'($urandom_range(1)));
        budget--; per_set++;
        if (pending_rsp[$].result_kind == KIND_EXHAUSTED && $urandom_range(3) == 0) break;
      end
      park_sender();  // sender holds off until all results are back
    end
  endtask

  initial begin
    n_fail = 0; n_items = 0; n_rsp = 0; n_cfg = 0; n_taken = 0; n_aborts = 0;
    cycles = 0;
    no_idle = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    rebuild_tree(0);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_tree();
    test_single_member();
    test_protocol_errors();
    test_full_size();
    no_idle = 1'b1;  // long burst with the sender never idling
    test_random_walks(160);
    no_idle = 1'b0;
    test_random_walks(250);
    park_sender();

    $display("Covered %0d requests, %0d results, %0d count writes (0 to 127).",
             n_items, n_rsp, n_cfg);
    $display("Members taken: %0d, walks abandoned: %0d.", n_taken, n_aborts);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
